@@ src/pfa_pkg.sv @@
package pfa_pkg;

  // Address geometry
  localparam int OFFSET_BITS   = 10;
  localparam int PAGE_BITS     = 5;
  localparam int SEGMENT_BITS  = 5;
  localparam int VPAGE_BITS    = PAGE_BITS + SEGMENT_BITS;
  localparam int VPAGES        = 1 << VPAGE_BITS;
  localparam int ADDR_BITS     = OFFSET_BITS + VPAGE_BITS;
  localparam int PAGE_BYTES    = 1 << OFFSET_BITS;

  // Frames and processes
  localparam int FRAME_COUNT   = 1024;
  localparam int FRAME_BITS    = $clog2(FRAME_COUNT);
  localparam int PROCESS_COUNT = 16;
  localparam int PID_BITS      = 5;
  localparam int PIDX_BITS     = $clog2(PROCESS_COUNT);

  // Item fields
  localparam int CMD_BITS      = 2;
  localparam int SIZE_BITS     = 21;
  localparam int DATA_BITS     = 8;
  localparam int PAGES_BITS    = SIZE_BITS - OFFSET_BITS + 1;
  localparam int MAP_BITS      = PIDX_BITS + VPAGE_BITS;
  localparam int RAM_BITS      = FRAME_BITS + OFFSET_BITS;
  localparam int RAM_DEPTH     = 1 << RAM_BITS;
  localparam int MAP_DEPTH     = 1 << MAP_BITS;

  // Stream widths
  localparam int IN_FIELD_BITS  = PID_BITS + ADDR_BITS + SIZE_BITS + DATA_BITS;
  localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = ADDR_BITS + DATA_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_WRITE = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN_COUNT,
    ST_SCAN_TAKE,
    ST_MAP_RD,
    ST_FRM_RD,
    ST_FREE_STEP,
    ST_RAM_RD,
    ST_RESP
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic clr_step;
    logic scan_start;
    logic scan_take;
    logic map_rd;
    logic frm_rd_map;
    logic frm_rd_link;
    logic free_clear;
    logic rw_access;
    logic alloc_commit;
    logic set_fail;
    logic set_ok;
    logic out_load;
  } pfa_ctrl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clear_last;
    logic bad_pid;
    cmd_e cmd;
    logic quick_fail;
    logic scan_done;
    logic enough;
    logic map_hit;
    logic owner_ok;
    logic first_ok;
    logic link_end;
    logic out_free;
  } pfa_stat_t;

endpackage

@@ src/paged_frame_allocator_translator_top.sv @@
// Paged frame allocator and address translator. Each input transfer carries one
// command (allocate, free, read byte, write byte) from one process; each gives
// exactly one result transfer. After reset the block sweeps its byte memory and
// frame owner table, one entry per cycle, and takes no command until that is done.
// A read goes through a page map read, a frame table read and a byte memory read;
// a write and a failed lookup stop sooner. Free walks the chain of frames in the
// block, one frame table read per step of the chain. Allocate scans the frame
// owner table up to twice, once to count free frames and, if there are enough,
// once to claim them, one frame per cycle. One command is in work at a time; a
// finished result waits in an output register while the next command is taken.
module paged_frame_allocator_translator_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // process_id, address, request_size, write_data from the lowest bit up
  input  logic [pfa_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
  // command
  input  logic [pfa_pkg::CMD_BITS-1:0]       s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // result_address, read_data from the lowest bit up
  output logic [pfa_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
  // status
  output logic [0:0]                         m_axis_tuser
);
  import pfa_pkg::*;

  pfa_ctrl_t ctrl;
  pfa_stat_t stat;

  pfa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .stat_i    (stat),
    .ctrl_o    (ctrl)
  );

  pfa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .in_cmd_i    (s_axis_tuser),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_status_o(m_axis_tuser[0])
  );

  // A failed command returns all-zero data
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("failed command with nonzero result data");

endmodule

@@ src/pfa_ram.sv @@
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ src/pfa_dp.sv @@
module pfa_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // process_id, address, request_size, write_data from the lowest bit up
  input  logic [pfa_pkg::IN_TDATA_BITS-1:0]    in_data_i,
  input  logic [pfa_pkg::CMD_BITS-1:0]         in_cmd_i,
  input  pfa_pkg::pfa_ctrl_t                   ctrl_i,
  output pfa_pkg::pfa_stat_t                   stat_o,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  // result_address, read_data from the lowest bit up
  output logic [pfa_pkg::OUT_TDATA_BITS-1:0]   out_data_o,
  output logic                                 out_status_o
);
  import pfa_pkg::*;

  localparam int OUT_PAD = OUT_TDATA_BITS - OUT_FIELD_BITS;

  // Input field split
  logic [PID_BITS-1:0]    pid_in;
  logic [ADDR_BITS-1:0]   addr_in;
  logic [SIZE_BITS-1:0]   size_in;
  logic [DATA_BITS-1:0]   wdata_in;
  logic [SIZE_BITS:0]     size_sum;
  logic [PIDX_BITS-1:0]   pidx_in;

  assign pid_in   = in_data_i[PID_BITS-1:0];
  assign addr_in  = in_data_i[PID_BITS +: ADDR_BITS];
  assign size_in  = in_data_i[PID_BITS+ADDR_BITS +: SIZE_BITS];
  assign wdata_in = in_data_i[PID_BITS+ADDR_BITS+SIZE_BITS +: DATA_BITS];
  assign size_sum = {1'b0, size_in} + (SIZE_BITS+1)'(PAGE_BYTES - 1);
  assign pidx_in  = PIDX_BITS'(pid_in - PID_BITS'(1));

  // Captured command
  cmd_e                   cmd_q;
  logic [PID_BITS-1:0]    pid_q;
  logic [PIDX_BITS-1:0]   pidx_q;
  logic [VPAGE_BITS-1:0]  vpn_q;
  logic [OFFSET_BITS-1:0] off_q;
  logic [PAGES_BITS-1:0]  pages_q;
  logic [DATA_BITS-1:0]   wdata_q;
  logic [VPAGE_BITS-1:0]  start_q;
  logic [VPAGE_BITS-1:0]  bp_q [PROCESS_COUNT];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q   <= cmd_e'(in_cmd_i);
      pid_q   <= pid_in;
      pidx_q  <= pidx_in;
      vpn_q   <= addr_in[ADDR_BITS-1:OFFSET_BITS];
      off_q   <= addr_in[OFFSET_BITS-1:0];
      pages_q <= size_sum[SIZE_BITS:OFFSET_BITS];
      wdata_q <= wdata_in;
      start_q <= bp_q[pidx_in];
    end
  end

  // Break pointers, kept in pages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PROCESS_COUNT; i++) begin
        bp_q[i] <= '0;
      end
    end else if (ctrl_i.alloc_commit) begin
      bp_q[pidx_q] <= start_q + pages_q[VPAGE_BITS-1:0];
    end
  end

  // Clearing sweep counter
  logic [RAM_BITS-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (ctrl_i.clr_step) begin
      clr_cnt_q <= clr_cnt_q + RAM_BITS'(1);
    end
  end

  // Frame scan: read owner table in order, process one entry behind
  logic [FRAME_BITS:0]   cnt_q;
  logic                  pend_q;
  logic [FRAME_BITS-1:0] pend_idx_q;
  logic                  take_q;
  logic [FRAME_BITS:0]   found_q;
  logic [FRAME_BITS-1:0] prev_q;
  logic                  scan_issue;
  logic                  hit_free;
  logic                  take_wr;
  logic [PID_BITS-1:0]   owner_rdata;
  logic [FRAME_BITS-1:0] pos_rdata;
  logic [FRAME_BITS:0]   link_rdata;
  logic [FRAME_BITS-1:0] map_rdata;
  logic [DATA_BITS-1:0]  ram_rdata;

  assign scan_issue = cnt_q < (FRAME_BITS+1)'(FRAME_COUNT);
  assign hit_free   = pend_q && (owner_rdata == '0) && (PAGES_BITS'(found_q) < pages_q);
  assign take_wr    = hit_free && take_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= (FRAME_BITS+1)'(FRAME_COUNT);
      pend_q  <= 1'b0;
      take_q  <= 1'b0;
      found_q <= '0;
    end else if (ctrl_i.scan_start) begin
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      take_q  <= ctrl_i.scan_take;
      found_q <= '0;
    end else begin
      pend_q <= scan_issue;
      if (scan_issue) begin
        cnt_q <= cnt_q + (FRAME_BITS+1)'(1);
      end
      if (hit_free) begin
        found_q <= found_q + (FRAME_BITS+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= cnt_q[FRAME_BITS-1:0];
    if (take_wr) begin
      prev_q <= pend_idx_q;
    end
  end

  // Current frame of a walk or an access
  logic [FRAME_BITS-1:0] cur_q;
  logic [FRAME_BITS-1:0] frm_addr;
  logic                  frm_re;

  assign frm_addr = ctrl_i.frm_rd_map ? map_rdata : link_rdata[FRAME_BITS-1:0];
  assign frm_re   = ctrl_i.frm_rd_map | ctrl_i.frm_rd_link;

  always_ff @(posedge clk_i) begin
    if (frm_re) begin
      cur_q <= frm_addr;
    end
  end

  // Frame owner table
  logic                  owner_we;
  logic [FRAME_BITS-1:0] owner_waddr;

  assign owner_we    = ctrl_i.clr_step | take_wr | ctrl_i.free_clear;
  assign owner_waddr = ctrl_i.clr_step ? clr_cnt_q[FRAME_BITS-1:0] :
                       take_wr         ? pend_idx_q : cur_q;

  pfa_ram #(.WIDTH(PID_BITS), .DEPTH(FRAME_COUNT)) u_owner (
    .clk_i  (clk_i),
    .we_i   (owner_we),
    .waddr_i(owner_waddr),
    .wdata_i(take_wr ? pid_q : '0),
    .re_i   (scan_issue | frm_re),
    .raddr_i(scan_issue ? cnt_q[FRAME_BITS-1:0] : frm_addr),
    .rdata_o(owner_rdata)
  );

  // Frame position in its block
  pfa_ram #(.WIDTH(FRAME_BITS), .DEPTH(FRAME_COUNT)) u_pos (
    .clk_i  (clk_i),
    .we_i   (take_wr),
    .waddr_i(pend_idx_q),
    .wdata_i(found_q[FRAME_BITS-1:0]),
    .re_i   (frm_re),
    .raddr_i(frm_addr),
    .rdata_o(pos_rdata)
  );

  // Next frame link; top bit marks the block end
  logic                link_we;
  logic [FRAME_BITS:0] link_wdata;

  assign link_we    = (take_wr && (found_q != '0)) | ctrl_i.alloc_commit;
  assign link_wdata = ctrl_i.alloc_commit ? {1'b1, {FRAME_BITS{1'b0}}} : {1'b0, pend_idx_q};

  pfa_ram #(.WIDTH(FRAME_BITS+1), .DEPTH(FRAME_COUNT)) u_link (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(prev_q),
    .wdata_i(link_wdata),
    .re_i   (frm_re),
    .raddr_i(frm_addr),
    .rdata_o(link_rdata)
  );

  // Page map; an entry is valid exactly when its page lies below the break
  logic [VPAGE_BITS-1:0] map_page;

  assign map_page = start_q + found_q[VPAGE_BITS-1:0];

  pfa_ram #(.WIDTH(FRAME_BITS), .DEPTH(MAP_DEPTH)) u_map (
    .clk_i  (clk_i),
    .we_i   (take_wr),
    .waddr_i({pidx_q, map_page}),
    .wdata_i(pend_idx_q),
    .re_i   (ctrl_i.map_rd),
    .raddr_i({pidx_q, vpn_q}),
    .rdata_o(map_rdata)
  );

  // Byte memory
  logic ram_we;
  logic ram_re;

  assign ram_we = ctrl_i.clr_step | (ctrl_i.rw_access && (cmd_q == CMD_WRITE));
  assign ram_re = ctrl_i.rw_access && (cmd_q == CMD_READ);

  pfa_ram #(.WIDTH(DATA_BITS), .DEPTH(RAM_DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ctrl_i.clr_step ? clr_cnt_q : {cur_q, off_q}),
    .wdata_i(ctrl_i.clr_step ? '0 : wdata_q),
    .re_i   (ram_re),
    .raddr_i({cur_q, off_q}),
    .rdata_o(ram_rdata)
  );

  // Result of the current command
  logic                 ok_q;
  logic [ADDR_BITS-1:0] res_addr_q;
  logic [DATA_BITS-1:0] res_data_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.set_fail) begin
      ok_q       <= 1'b0;
      res_addr_q <= '0;
      res_data_q <= '0;
    end else if (ctrl_i.set_ok) begin
      ok_q       <= 1'b1;
      res_addr_q <= (cmd_q == CMD_ALLOC) ? {start_q, {OFFSET_BITS{1'b0}}} : '0;
      res_data_q <= (cmd_q == CMD_READ) ? ram_rdata : '0;
    end
  end

  // Output register
  logic                 out_valid_q;
  logic                 out_status_q;
  logic [ADDR_BITS-1:0] out_addr_q;
  logic [DATA_BITS-1:0] out_rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      out_status_q <= ~ok_q;
      out_addr_q   <= res_addr_q;
      out_rdata_q  <= res_data_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_data_o   = {{OUT_PAD{1'b0}}, out_rdata_q, out_addr_q};

  // Status toward the controller
  always_comb begin
    stat_o.clear_last = &clr_cnt_q;
    stat_o.bad_pid    = (pid_q == '0) || (pid_q > PID_BITS'(PROCESS_COUNT));
    stat_o.cmd        = cmd_q;
    stat_o.quick_fail = (pages_q == '0) ||
                        (pages_q > PAGES_BITS'(FRAME_COUNT)) ||
                        (((PAGES_BITS+1)'(start_q) + (PAGES_BITS+1)'(pages_q)) >=
                         (PAGES_BITS+1)'(VPAGES));
    stat_o.scan_done  = !scan_issue && !pend_q;
    stat_o.enough     = PAGES_BITS'(found_q) == pages_q;
    stat_o.map_hit    = vpn_q < start_q;
    stat_o.owner_ok   = owner_rdata == pid_q;
    stat_o.first_ok   = pos_rdata == '0;
    stat_o.link_end   = link_rdata[FRAME_BITS];
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

@@ src/pfa_ctrl.sv @@
module pfa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pfa_pkg::pfa_stat_t stat_i,
  output pfa_pkg::pfa_ctrl_t ctrl_o
);
  import pfa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (stat_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (stat_i.bad_pid) begin
          state_d = ST_RESP;
        end else if (stat_i.cmd == CMD_ALLOC) begin
          state_d = stat_i.quick_fail ? ST_RESP : ST_SCAN_COUNT;
        end else begin
          state_d = ST_MAP_RD;
        end
      end
      ST_SCAN_COUNT: begin
        if (stat_i.scan_done) state_d = stat_i.enough ? ST_SCAN_TAKE : ST_RESP;
      end
      ST_SCAN_TAKE: begin
        if (stat_i.scan_done) state_d = ST_RESP;
      end
      ST_MAP_RD: begin
        state_d = stat_i.map_hit ? ST_FRM_RD : ST_RESP;
      end
      ST_FRM_RD: begin
        if (!stat_i.owner_ok) begin
          state_d = ST_RESP;
        end else if (stat_i.cmd == CMD_FREE) begin
          if (!stat_i.first_ok || stat_i.link_end) state_d = ST_RESP;
          else state_d = ST_FREE_STEP;
        end else if (stat_i.cmd == CMD_READ) begin
          state_d = ST_RAM_RD;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_FREE_STEP: begin
        if (stat_i.link_end) state_d = ST_RESP;
      end
      ST_RAM_RD: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    ctrl_o = '0;
    case (state_q)
      ST_CLEAR: begin
        ctrl_o.clr_step = 1'b1;
      end
      ST_IDLE: begin
        ctrl_o.load = in_valid_i;
      end
      ST_DECIDE: begin
        if (stat_i.bad_pid) begin
          ctrl_o.set_fail = 1'b1;
        end else if (stat_i.cmd == CMD_ALLOC) begin
          if (stat_i.quick_fail) ctrl_o.set_fail = 1'b1;
          else ctrl_o.scan_start = 1'b1;
        end else begin
          ctrl_o.map_rd = 1'b1;
        end
      end
      ST_SCAN_COUNT: begin
        if (stat_i.scan_done) begin
          if (stat_i.enough) begin
            ctrl_o.scan_start = 1'b1;
            ctrl_o.scan_take  = 1'b1;
          end else begin
            ctrl_o.set_fail = 1'b1;
          end
        end
      end
      ST_SCAN_TAKE: begin
        if (stat_i.scan_done) begin
          ctrl_o.alloc_commit = 1'b1;
          ctrl_o.set_ok       = 1'b1;
        end
      end
      ST_MAP_RD: begin
        if (stat_i.map_hit) ctrl_o.frm_rd_map = 1'b1;
        else ctrl_o.set_fail = 1'b1;
      end
      ST_FRM_RD: begin
        if (!stat_i.owner_ok) begin
          ctrl_o.set_fail = 1'b1;
        end else if (stat_i.cmd == CMD_FREE) begin
          if (!stat_i.first_ok) begin
            ctrl_o.set_fail = 1'b1;
          end else begin
            ctrl_o.free_clear = 1'b1;
            if (stat_i.link_end) ctrl_o.set_ok = 1'b1;
            else ctrl_o.frm_rd_link = 1'b1;
          end
        end else begin
          ctrl_o.rw_access = 1'b1;
          if (stat_i.cmd == CMD_WRITE) ctrl_o.set_ok = 1'b1;
        end
      end
      ST_FREE_STEP: begin
        ctrl_o.free_clear = 1'b1;
        if (stat_i.link_end) ctrl_o.set_ok = 1'b1;
        else ctrl_o.frm_rd_link = 1'b1;
      end
      ST_RAM_RD: begin
        ctrl_o.set_ok = 1'b1;
      end
      ST_RESP: begin
        ctrl_o.out_load = stat_i.out_free;
      end
      default: begin
        ctrl_o = '0;
      end
    endcase
  end

  assign in_ready_o = state_q == ST_IDLE;

  // A load always leads to the decode step
  a_load_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.load |=> state_q == ST_DECIDE)
    else $error("load not followed by decode");

  // Chain walk only continues from a frame read
  a_walk_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FREE_STEP |-> $past(state_q == ST_FRM_RD || state_q == ST_FREE_STEP))
    else $error("free walk entered without a checked first frame");

  // The take pass finds every frame the count pass found
  a_take_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN_TAKE && stat_i.scan_done |-> stat_i.enough)
    else $error("allocation took fewer frames than counted");

  // Result never loaded over an untaken one
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.out_load |-> stat_i.out_free)
    else $error("result register overwritten");

endmodule

@@ bench/tb.sv @@
module tb;
  import pfa_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_BITS-1:0] s_axis_tdata = '0;
  logic [CMD_BITS-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;

  paged_frame_allocator_translator_top uut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  typedef struct {
    cmd_e        cmd;
    logic [4:0]  pid;
    logic [19:0] addr;
    logic [20:0] size;
    logic [7:0]  wdata;
  } mmu_cmd_t;

  typedef struct {
    logic        status;
    logic [19:0] start_addr;
    logic [7:0]  rdata;
    bit          typed;
  } mmu_resp_t;

  // Shadow copy of the allocator state
  logic [4:0]  own_tbl [FRAME_COUNT];
  logic [9:0]  pos_tbl [FRAME_COUNT];
  int          link_tbl [FRAME_COUNT];
  int          map_tbl [int];
  int          brk_tbl [PROCESS_COUNT];
  logic [7:0]  mem_tbl [int];

  mmu_resp_t resp_q[$];
  int n_fail = 0;
  int n_done = 0;
  bit no_idle = 1'b0;
  int dir_exp [int];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #1000000000;
    $display("[paged_frame_allocator_translator_top] ERROR");
    $finish;
  end

  function automatic int map_key(int pid, int addr);
    return ((pid - 1) << VPAGE_BITS) | ((addr >> OFFSET_BITS) & (VPAGES - 1));
  endfunction

  // Return mapped frame or -1
  function automatic int lookup_frame(int pid, int addr);
    int k;
    k = map_key(pid, addr);
    return map_tbl.exists(k) ? map_tbl[k] : -1;
  endfunction

  function automatic int phys_of(int pid, int addr);
    int f;
    f = lookup_frame(pid, addr);
    if (f < 0 || own_tbl[f] != pid) return -1;
    return (f << OFFSET_BITS) | (addr & (PAGE_BYTES - 1));
  endfunction

  function automatic mmu_resp_t mmu_apply(mmu_cmd_t c);
    mmu_resp_t r;
    int pages, f, p, bp, steps;
    int pick [$];
    r = '{1'b1, '0, '0, 1'b0};
    if (c.pid < 1 || c.pid > PROCESS_COUNT) return r;
    case (c.cmd)
      CMD_ALLOC: begin
        pages = (int'(c.size) + PAGE_BYTES - 1) >> OFFSET_BITS;
        if (pages == 0 || pages > FRAME_COUNT) return r;
        for (int i = 0; i < FRAME_COUNT && pick.size() < pages; i++)
          if (own_tbl[i] == 0) pick.push_back(i);
        if (pick.size() < pages) return r;
        bp = brk_tbl[c.pid-1];
        if (bp + pages * PAGE_BYTES >= (1 << ADDR_BITS)) return r;
        r.status = 1'b0;
        r.start_addr = bp[19:0];
        for (int i = 0; i < pages; i++) begin
          own_tbl[pick[i]] = c.pid;
          pos_tbl[pick[i]] = 10'(i);
          link_tbl[pick[i]] = (i + 1 < pages) ? pick[i+1] : -1;
          map_tbl[map_key(c.pid, bp)] = pick[i];
          bp += PAGE_BYTES;
        end
        brk_tbl[c.pid-1] = bp;
      end
      CMD_FREE: begin
        f = lookup_frame(c.pid, c.addr);
        if (f < 0 || own_tbl[f] != c.pid || pos_tbl[f] != 0) return r;
        for (steps = 0; steps < FRAME_COUNT; steps++) begin
          own_tbl[f] = 0;
          if (link_tbl[f] < 0) break;
          f = link_tbl[f];
        end
        r.status = 1'b0;
      end
      CMD_READ: begin
        p = phys_of(c.pid, c.addr);
        if (p < 0) return r;
        r.status = 1'b0;
        r.rdata = mem_tbl.exists(p) ? mem_tbl[p] : 8'h00;
      end
      default: begin
        p = phys_of(c.pid, c.addr);
        if (p < 0) return r;
        r.status = 1'b0;
        mem_tbl[p] = c.wdata;
      end
    endcase
    return r;
  endfunction

  // Send one command; idx >= 0 selects a typed expectation if one is listed
  task automatic send_cmd(mmu_cmd_t c, int idx = -1);
    mmu_resp_t r;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c.cmd;
    s_axis_tdata  <= IN_TDATA_BITS'({c.wdata, c.size, c.addr, c.pid});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = mmu_apply(c);
    if (idx >= 0 && dir_exp.exists(idx)) begin
      if (r.status != dir_exp[idx][0]) begin
        $error("table row %0d: predictor status %0d", idx, r.status);
        n_fail++;
      end
      r.status = dir_exp[idx][0];
      r.typed = 1'b1;
    end
    resp_q.push_back(r);
    @(negedge clk_i);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    mmu_resp_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (resp_q.size() == 0) begin
        $error("result with no command outstanding");
        n_fail++;
      end else begin
        e = resp_q.pop_front();
        if (m_axis_tuser[0] !== e.status) begin
          $error("status exp %0d got %0d", e.status, m_axis_tuser[0]); n_fail++;
        end
        if (m_axis_tdata[19:0] !== e.start_addr) begin
          $error("result_address exp %0h got %0h", e.start_addr, m_axis_tdata[19:0]);
          n_fail++;
        end
        if (m_axis_tdata[27:20] !== e.rdata) begin
          $error("read_data exp %0h got %0h", e.rdata, m_axis_tdata[27:20]); n_fail++;
        end
      end
      n_done++;
    end
  end

  // Drive receiver stalls
  initial begin
    forever begin
      @(negedge clk_i);
      if (!no_idle && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  function automatic mmu_cmd_t mk(cmd_e c, int pid, int addr, int size, int wd);
    mmu_cmd_t m;
    m.cmd = c; m.pid = 5'(pid); m.addr = 20'(addr); m.size = 21'(size); m.wdata = 8'(wd);
    return m;
  endfunction

  initial begin
    mmu_cmd_t dir_tbl [$];
    mmu_cmd_t c;
    int live_pid [$];
    int live_base [$];
    int k, pid, lim;
    for (int i = 0; i < FRAME_COUNT; i++) begin
      own_tbl[i] = 0; pos_tbl[i] = 0; link_tbl[i] = -1;
    end
    foreach (brk_tbl[i]) brk_tbl[i] = 0;

    // Directed rows; expected status typed where obvious
    dir_tbl.push_back(mk(CMD_READ, 1, 0, 0, 0));         dir_exp[0] = 1; // unmapped
    dir_tbl.push_back(mk(CMD_ALLOC, 0, 0, 100, 0));      dir_exp[1] = 1; // bad pid
    dir_tbl.push_back(mk(CMD_ALLOC, 17, 0, 100, 0));     dir_exp[2] = 1;
    dir_tbl.push_back(mk(CMD_WRITE, 31, 5, 0, 8'hff));   dir_exp[3] = 1;
    dir_tbl.push_back(mk(CMD_ALLOC, 1, 0, 0, 0));        dir_exp[4] = 1; // zero size
    dir_tbl.push_back(mk(CMD_ALLOC, 1, 0, 1, 0));        dir_exp[5] = 0;
    dir_tbl.push_back(mk(CMD_WRITE, 1, 1023, 0, 8'hff)); dir_exp[6] = 0;
    dir_tbl.push_back(mk(CMD_READ, 1, 1023, 0, 0));
    dir_tbl.push_back(mk(CMD_READ, 2, 1023, 0, 0));      dir_exp[8] = 1; // unmapped
    dir_tbl.push_back(mk(CMD_ALLOC, 16, 0, 3000, 0));
    dir_tbl.push_back(mk(CMD_WRITE, 16, 2100, 0, 8'h5a));
    dir_tbl.push_back(mk(CMD_FREE, 16, 1024, 0, 0));     dir_exp[11] = 1; // not first
    dir_tbl.push_back(mk(CMD_FREE, 16, 777, 0, 0));      dir_exp[12] = 0;
    dir_tbl.push_back(mk(CMD_READ, 16, 2100, 0, 0));     dir_exp[13] = 1; // stale
    dir_tbl.push_back(mk(CMD_ALLOC, 2, 0, 1048576, 0));  dir_exp[14] = 1; // limit
    dir_tbl.push_back(mk(CMD_ALLOC, 3, 0, 1047553, 0));  dir_exp[15] = 1; // too few
    dir_tbl.push_back(mk(CMD_ALLOC, 4, 0, 1000000, 0));
    dir_tbl.push_back(mk(CMD_ALLOC, 5, 0, 20000, 0));
    dir_tbl.push_back(mk(CMD_FREE, 4, 0, 0, 0));
    dir_tbl.push_back(mk(CMD_ALLOC, 5, 0, 2048, 0));
    dir_tbl.push_back(mk(CMD_WRITE, 5, 21504, 0, 8'h00));
    dir_tbl.push_back(mk(CMD_READ, 5, 21504, 0, 0));
    dir_tbl.push_back(mk(CMD_FREE, 1, 0, 0, 0));
    dir_tbl.push_back(mk(CMD_READ, 1, 1023, 0, 0));      dir_exp[23] = 1;

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tbl[i]) send_cmd(dir_tbl[i], i);

    // Random commands, mostly on live blocks
    for (int n = 0; n < 1650; n++) begin
      if (n > 1500) no_idle = 1'b1;
      k = $urandom_range(0, 99);
      pid = $urandom_range(1, 16);
      c = mk(cmd_e'($urandom_range(0, 3)), pid, $urandom, $urandom, $urandom);
      c.addr = 20'($urandom); c.size = 21'($urandom); c.wdata = 8'($urandom);
      if (k < 5) c.pid = 5'($urandom);
      else if (k < 20) begin
        c.cmd = CMD_ALLOC;
        c.size = ($urandom_range(0, 15) == 0) ? 21'($urandom) : 21'($urandom_range(1, 9000));
        lim = brk_tbl[pid-1];
        if (lim > 900000) c.size = 21'($urandom_range(1, 2048));
      end else if (k < 28 && live_pid.size() > 0) begin
        k = $urandom_range(0, live_pid.size() - 1);
        c.cmd = CMD_FREE; c.pid = 5'(live_pid[k]);
        c.addr = 20'(live_base[k] + $urandom_range(0, 1023));
        live_pid.delete(k); live_base.delete(k);
      end else if (live_pid.size() > 0 && k < 92) begin
        k = $urandom_range(0, live_pid.size() - 1);
        c.cmd = $urandom_range(0, 1) ? CMD_READ : CMD_WRITE;
        c.pid = 5'(live_pid[k]);
        c.addr = 20'(live_base[k] + $urandom_range(0, 4095));
      end
      if (c.cmd == CMD_ALLOC) begin
        lim = (c.pid >= 1 && c.pid <= 16) ? brk_tbl[c.pid-1] : 0;
        send_cmd(c);
        if (resp_q[$].status == 1'b0) begin
          live_pid.push_back(c.pid); live_base.push_back(lim);
        end
      end else send_cmd(c);
    end
    s_axis_tvalid <= 1'b0;

    lim = 0;
    while (resp_q.size() > 0 && lim < 2000000) begin
      @(posedge clk_i); lim++;
    end
    repeat (50) @(posedge clk_i);
    if (n_fail == 0 && resp_q.size() == 0)
      $display("[paged_frame_allocator_translator_top] OK");
    else
      $display("[paged_frame_allocator_translator_top] ERROR");
    $finish;
  end

endmodule
